FILE: src/sfr_pkg.sv
// Package: shared types and constants for the stream find-and-replace block.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    // Input transaction payload
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_input;
    } in_item_t;

    // Output transaction payload
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              end_of_output;
    } out_item_t;

    // Per-cell control of the lookahead window
    typedef struct packed {
        logic shift;       // take the byte of the upper neighbour
        logic write_here;  // take the incoming byte
        logic held_live;   // cell holds a byte of the current window
    } win_ctrl_t;

    // Shared control of the emit chain
    typedef struct packed {
        logic load;   // load a fresh result list
        logic shift;  // move every entry one place towards the head
    } emit_ctrl_t;

endpackage

FILE: src/sfr_win_cell.sv
// One cell of the lookahead window: holds a byte and compares it with its pattern byte.
`timescale 1ns / 1ps

module sfr_win_cell
    import sfr_pkg::*;
(
    input  logic              clk,
    input  win_ctrl_t         ctrl,
    input  logic [BYTE_W-1:0] new_byte,
    input  logic [BYTE_W-1:0] next_byte,
    input  logic [BYTE_W-1:0] pat_byte,
    output logic [BYTE_W-1:0] cur_byte,
    output logic              eq
);

    logic [BYTE_W-1:0] win_reg;
    logic [BYTE_W-1:0] win_next;

    // Window byte as seen with the incoming byte appended
    assign cur_byte = ctrl.held_live ? win_reg : new_byte;
    assign eq       = (cur_byte == pat_byte);

    // Shift down on a mismatch, otherwise store the incoming byte at the fill point
    always_comb
    begin
        if (ctrl.shift)
        begin
            win_next = next_byte;
        end
        else if (ctrl.write_here)
        begin
            win_next = new_byte;
        end
        else
        begin
            win_next = win_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

FILE: src/sfr_emit_cell.sv
// One cell of the emit chain: holds a pending result and passes it towards the head.
`timescale 1ns / 1ps

module sfr_emit_cell
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  emit_ctrl_t ctrl,
    input  logic       load_valid,
    input  out_item_t  load_item,
    input  logic       next_valid,
    input  out_item_t  next_item,
    output logic       valid,
    output out_item_t  item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;
    out_item_t item_next;

    // Load wins: the chain is empty after the shift whenever a load happens
    always_comb
    begin
        if (ctrl.load)
        begin
            valid_next = load_valid;
            item_next  = load_item;
        end
        else if (ctrl.shift)
        begin
            valid_next = next_valid;
            item_next  = next_item;
        end
        else
        begin
            valid_next = valid_reg;
            item_next  = item_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

FILE: src/stream_find_replace.sv
// Top level: streaming find-and-replace over bytes with a row of window cells and an emit chain.
// Latency: an accepted input is loaded into the emit chain, and its first result then passes to the output register.
// Throughput: one input transaction per cycle while each item yields at most one result and the output is not stalled;
// an item that yields k results occupies the emit chain and output register until all k have moved out.
// Reset: window count, emit chain and output valid clear; registers return to pattern 0,
// pattern length 1, replacement 0, replacement length 0. Window bytes are not reset.
`timescale 1ns / 1ps

module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QD = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int RW = $clog2(MAX_REPLACEMENT + 1);
    localparam int NW = $clog2(QD + 1);
    localparam int PB = MAX_PATTERN * BYTE_W;
    localparam int RB = MAX_REPLACEMENT * BYTE_W;

    // Configuration registers (lengths held as effective values)
    logic [PB-1:0] pat_reg;
    logic [PB-1:0] pat_next;
    logic [CW-1:0] plen_reg;
    logic [CW-1:0] plen_next;
    logic [RB-1:0] rep_reg;
    logic [RB-1:0] rep_next;
    logic [RW-1:0] rlen_reg;
    logic [RW-1:0] rlen_next;

    logic [CW-1:0] wc_reg;
    logic [CW-1:0] wc_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_item_reg;
    out_item_t     out_item_next;

    logic [LEN_W-1:0] cfg_len;
    logic             cfg_wr;

    // Window signals
    win_ctrl_t         win_ctrl [MAX_PATTERN];
    logic [BYTE_W-1:0] cur_byte [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] eq;
    logic [BYTE_W-1:0] win_lane [QD];
    logic [BYTE_W-1:0] rep_lane [QD];

    // Step decode
    logic          accept;
    logic          advance;
    logic          last;
    logic          stale;
    logic          full;
    logic          match_all;
    logic          match;
    logic          mismatch_shift;
    logic          bare;
    logic [CW-1:0] wc_inc;
    logic [NW-1:0] n_raw;
    logic [NW-1:0] n_eff;

    // Emit chain signals
    emit_ctrl_t emit_ctrl;
    logic       load_valid [QD];
    out_item_t  load_item  [QD];
    logic       q_valid    [QD+1];
    out_item_t  q_item     [QD+1];

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign cfg_len   = cfg_data[LEN_W-1:0];

    always_comb
    begin
        pat_next  = pat_reg;
        plen_next = plen_reg;
        rep_next  = rep_reg;
        rlen_next = rlen_reg;
        if (cfg_wr)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:
                begin
                    pat_next = cfg_data[PB-1:0];
                end
                REG_PATTERN_LENGTH:
                begin
                    // Clamp to 1..MAX_PATTERN
                    if (cfg_len == '0)
                    begin
                        plen_next = CW'(1);
                    end
                    else if (cfg_len > LEN_W'(MAX_PATTERN))
                    begin
                        plen_next = CW'(MAX_PATTERN);
                    end
                    else
                    begin
                        plen_next = cfg_len[CW-1:0];
                    end
                end
                REG_REPLACEMENT_BYTES:
                begin
                    rep_next = cfg_data[RB-1:0];
                end
                REG_REPLACEMENT_LENGTH:
                begin
                    // Clamp to 0..MAX_REPLACEMENT
                    if (cfg_len > LEN_W'(MAX_REPLACEMENT))
                    begin
                        rlen_next = RW'(MAX_REPLACEMENT);
                    end
                    else
                    begin
                        rlen_next = cfg_len[RW-1:0];
                    end
                end
                default:
                begin
                    pat_next = pat_reg;
                end
            endcase
        end
    end

    // Handshake: the output register advances when empty or taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance ? !q_valid[1] : !q_valid[0];
    assign accept   = in_valid && in_ready;
    assign last     = in_item.end_of_input;

    // Window state decode
    assign wc_inc = wc_reg + CW'(1);
    assign stale  = (wc_reg >= plen_reg);
    assign full   = !stale && (wc_inc == plen_reg);

    // Window cell row; the cell above the top takes the incoming byte
    assign cur_byte[MAX_PATTERN] = in_item.in_byte;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_win
        always_comb
        begin
            win_ctrl[i].shift      = mismatch_shift;
            win_ctrl[i].write_here = accept && !stale && !mismatch_shift
                                     && (wc_reg == CW'(i));
            win_ctrl[i].held_live  = (CW'(i) < wc_reg);
        end

        sfr_win_cell u_cell
        (
            .clk       (clk),
            .ctrl      (win_ctrl[i]),
            .new_byte  (in_item.in_byte),
            .next_byte (cur_byte[i+1]),
            .pat_byte  (pat_reg[i*BYTE_W +: BYTE_W]),
            .cur_byte  (cur_byte[i]),
            .eq        (eq[i])
        );
    end

    // Combine cell compares over the pattern length
    always_comb
    begin
        match_all = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((CW'(i) < plen_reg) && !eq[i])
            begin
                match_all = 1'b0;
            end
        end
    end

    assign match          = full && match_all;
    assign mismatch_shift = accept && full && !match_all;

    // Result lanes padded to the emit chain depth
    for (genvar k = 0; k < QD; k++)
    begin : g_lane
        if (k < MAX_PATTERN)
        begin : g_w
            assign win_lane[k] = cur_byte[k];
        end
        else
        begin : g_wz
            assign win_lane[k] = '0;
        end
        if (k < MAX_REPLACEMENT)
        begin : g_r
            assign rep_lane[k] = rep_reg[k*BYTE_W +: BYTE_W];
        end
        else
        begin : g_rz
            assign rep_lane[k] = '0;
        end
    end

    // Count results of this transaction
    always_comb
    begin
        if (match)
        begin
            n_raw = NW'(rlen_reg);
        end
        else if (stale || last)
        begin
            n_raw = NW'(wc_inc);
        end
        else if (full)
        begin
            n_raw = NW'(1);
        end
        else
        begin
            n_raw = '0;
        end
    end

    assign bare  = last && (n_raw == '0);
    assign n_eff = bare ? NW'(1) : n_raw;

    // Build the result list for the emit chain
    always_comb
    begin
        for (int k = 0; k < QD; k++)
        begin
            load_valid[k]              = (NW'(k) < n_eff);
            load_item[k].out_byte      = bare ? '0 : (match ? rep_lane[k] : win_lane[k]);
            load_item[k].has_byte      = !bare;
            load_item[k].end_of_output = last && (NW'(k + 1) == n_eff);
        end
    end

    // Emit chain; the slot past the tail is always empty
    assign emit_ctrl.load  = accept;
    assign emit_ctrl.shift = advance;
    assign q_valid[QD]     = 1'b0;
    assign q_item[QD]      = '0;

    for (genvar k = 0; k < QD; k++)
    begin : g_emit
        sfr_emit_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (emit_ctrl),
            .load_valid (load_valid[k]),
            .load_item  (load_item[k]),
            .next_valid (q_valid[k+1]),
            .next_item  (q_item[k+1]),
            .valid      (q_valid[k]),
            .item       (q_item[k])
        );
    end

    // Advance the window count
    always_comb
    begin
        wc_next = wc_reg;
        if (accept)
        begin
            if (stale || match || last)
            begin
                wc_next = '0;
            end
            else if (!full)
            begin
                wc_next = wc_inc;
            end
        end
    end

    // Output register takes the head of the emit chain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (advance)
        begin
            out_valid_next = q_valid[0];
            out_item_next  = q_item[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg       <= '0;
            plen_reg      <= CW'(1);
            rep_reg       <= '0;
            rlen_reg      <= '0;
            wc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pat_reg       <= pat_next;
            plen_reg      <= plen_next;
            rep_reg       <= rep_next;
            rlen_reg      <= rlen_next;
            wc_reg        <= wc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: dv/tb.sv
// Testbench for stream_find_replace: directed and random byte streams against a window predictor.
`timescale 1ns / 1ps

module tb
    import sfr_pkg::*;
();

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of the registers and the lookahead window
    logic [63:0]           pattern_q;
    logic [LEN_W-1:0]      pattern_len_q;
    logic [63:0]           replace_q;
    logic [LEN_W-1:0]      replace_len_q;
    logic [BYTE_W-1:0]     window_bytes [8];
    int                    window_fill;

    out_item_t             expected_out [$];
    out_item_t             head_item;
    int                    error_count;
    bit                    steady_flow;

    stream_find_replace dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_error(input string what, input out_item_t want, input out_item_t got);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%s: expected byte %02h has %0b end %0b, got byte %02h has %0b end %0b",
                     what, want.out_byte, want.has_byte, want.end_of_output,
                     got.out_byte, got.has_byte, got.end_of_output);
        end
    endtask

    // Append one result to the tail of a list
    task automatic queue_result(ref out_item_t list [$], input logic [BYTE_W-1:0] value,
                                input logic has);
        list.insert(list.size(), out_item_t'{value, has, 1'b0});
    endtask

    // Work out the results of one accepted byte and queue them
    task automatic predict_replace(input logic [BYTE_W-1:0] data, input logic last);
        out_item_t batch [$];
        out_item_t item;
        int        plen;
        int        rlen;
        bit        hit;
        plen = (pattern_len_q == 0) ? 1 : ((pattern_len_q > 8) ? 8 : int'(pattern_len_q));
        rlen = (replace_len_q > 8) ? 8 : int'(replace_len_q);
        if (window_fill >= plen)
        begin
            // stale window after a shorter pattern length: pass all through
            for (int i = 0; i < window_fill; i++)
                queue_result(batch, window_bytes[i], 1'b1);
            queue_result(batch, data, 1'b1);
            window_fill = 0;
        end
        else
        begin
            window_bytes[window_fill] = data;
            window_fill++;
            if (window_fill == plen)
            begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (window_bytes[i] != pattern_q[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (int i = 0; i < rlen; i++)
                        queue_result(batch, replace_q[8*i +: 8], 1'b1);
                    window_fill = 0;
                end
                else
                begin
                    queue_result(batch, window_bytes[0], 1'b1);
                    for (int i = 1; i < window_fill; i++)
                        window_bytes[i-1] = window_bytes[i];
                    window_fill--;
                end
            end
            // flush leftover lookahead at end of string
            if (last)
            begin
                for (int i = 0; i < window_fill; i++)
                    queue_result(batch, window_bytes[i], 1'b1);
                window_fill = 0;
            end
        end
        if (last)
        begin
            if (batch.size() == 0)
                queue_result(batch, 8'h00, 1'b0);
            item = batch.pop_back();
            item.end_of_output = 1'b1;
            batch.insert(batch.size(), item);
        end
        foreach (batch[i])
            expected_out.insert(expected_out.size(), batch[i]);
    endtask

    // Present one byte, idling now and then, and hold it until accepted
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
        while (!steady_flow && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{data, last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_replace(data, last);
    endtask

    // Hold off input until every expected result is out and the pipeline is quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PATTERN_BYTES:      pattern_q     = value;
            REG_PATTERN_LENGTH:     pattern_len_q = value[LEN_W-1:0];
            REG_REPLACEMENT_BYTES:  replace_q     = value;
            REG_REPLACEMENT_LENGTH: replace_len_q = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [63:0] pat, input logic [LEN_W-1:0] plen,
                              input logic [63:0] rep, input logic [LEN_W-1:0] rlen);
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH, {60'd0, plen});
        write_reg(REG_REPLACEMENT_BYTES, rep);
        write_reg(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
    endtask

    // Defaults after reset: a zero byte is deleted, so a lone end gives a bare marker
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // Near miss, then a match that expands to the full replacement, then a flush
    task automatic test_expanding_match();
        set_config(64'h0000_0000_0000_6261, 4'd2, 64'h8877_6655_4433_2211, 4'd15);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b1);
    endtask

    // Longest pattern deleted on the end byte leaves only the end marker
    task automatic test_full_length_delete();
        set_config('1, 4'd8, 64'd0, 4'd0);
        for (int i = 0; i < 8; i++)
            send_byte(8'hFF, i == 7);
    endtask

    // Shorten the pattern while the window holds bytes
    task automatic test_stale_window();
        set_config(64'd0, 4'd4, 64'hA5, 4'd1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        send_byte(8'h40, 1'b1);
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b1);
    endtask

    // Random settings per phase; strings seeded with whole and partial pattern runs
    task automatic test_random_streams();
        logic [BYTE_W-1:0] text [$];
        logic [LEN_W-1:0]  plen;
        int                plen_eff;
        int                sent;
        int                target;
        int                cut;
        bit                open_end;
        for (int phase = 0; phase < 10; phase++)
        begin
            steady_flow = (phase == 5);
            case ($urandom_range(9))
                0:       plen = 4'd0;
                1:       plen = 4'($urandom_range(9, 15));
                2:       plen = 4'd8;
                default: plen = 4'($urandom_range(1, 4));
            endcase
            if (phase == 0)
                set_config('1, 4'd15, '1, 4'd15);
            else if (phase == 1)
                set_config('0, 4'd0, '0, 4'd0);
            else
                set_config({$urandom, $urandom}, plen, {$urandom, $urandom},
                           4'($urandom_range(15)));
            plen_eff = (pattern_len_q == 0) ? 1 :
                       ((pattern_len_q > 8) ? 8 : int'(pattern_len_q));
            sent = 0;
            while (sent < 30)
            begin
                text.delete();
                target = $urandom_range(1, 12);
                while (text.size() < target)
                begin
                    case ($urandom_range(9))
                        0, 1, 2, 3:
                        begin
                            for (int i = 0; i < plen_eff; i++)
                                text.insert(text.size(), pattern_q[8*i +: 8]);
                        end
                        4, 5:
                        begin
                            cut = $urandom_range(plen_eff - 1);
                            for (int i = 0; i < cut; i++)
                                text.insert(text.size(), pattern_q[8*i +: 8]);
                            text.insert(text.size(), 8'($urandom_range(255)));
                        end
                        default: text.insert(text.size(), 8'($urandom_range(255)));
                    endcase
                end
                // leave the last string of some phases open across the next settings
                open_end = (sent + text.size() >= 30) && ($urandom_range(3) == 0);
                foreach (text[i])
                    send_byte(text[i], !open_end && (i == text.size() - 1));
                sent += text.size();
            end
        end
        steady_flow = 1'b0;
    endtask

    // Compare each accepted result with the oldest expectation; drive the stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_out.size() == 0)
                    report_error("unexpected result", '0, out_item);
                else
                begin
                    head_item = expected_out.pop_front();
                    if (out_item.out_byte !== head_item.out_byte ||
                        out_item.has_byte !== head_item.has_byte ||
                        out_item.end_of_output !== head_item.end_of_output)
                        report_error("result mismatch", head_item, out_item);
                end
            end
            out_ready <= steady_flow || ($urandom_range(99) >= 8);
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_PATTERN_BYTES;
        cfg_data      = '0;
        steady_flow   = 1'b0;
        error_count   = 0;
        pattern_q     = 64'd0;
        pattern_len_q = 4'd1;
        replace_q     = 64'd0;
        replace_len_q = 4'd0;
        window_fill   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_expanding_match();
        test_full_length_delete();
        test_stale_window();
        test_random_streams();

        wait_idle();
        repeat (10) @(posedge clk);
        while (expected_out.size() != 0)
            report_error("missing result", expected_out.pop_front(), '0);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: stream_find_replace.f
src/sfr_pkg.sv
src/sfr_win_cell.sv
src/sfr_emit_cell.sv
src/stream_find_replace.sv
dv/tb.sv
